// ----- hdl/tnc_pkg.sv -----
// Shared types, codes and constants of the Tokhura nearest-codeword encoder.
// Depends on nothing; every other file of the block but the codeword store imports it.
package tnc_pkg;

   localparam int DIST_BITS   = 44;
   localparam int WEIGHT_BITS = 6;
   localparam int REGION_BITS = 3;

   // Codebook shape; the request and result fields are sized for it.
   localparam int CODEBOOK_ENTRIES = 8;
   localparam int VECTOR_LENGTH    = 12;

   localparam logic [DIST_BITS-1:0] DIST_MAX    = 44'hFFF_FFFF_FFFF;
   localparam logic [DIST_BITS-1:0] LIMIT_RESET = 44'd1677704822784;
   localparam logic [3:0]           SIZE_RESET  = 4'd1;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_TRAIN = 1'b1
   } req_kind_type;

   typedef enum logic [0:0] {
      CSR_CODEBOOK_SIZE  = 1'b0,
      CSR_NO_MATCH_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } seq_state_type;

   // One issue slot from the sequencer to the shared unit.
   typedef struct packed {
      logic issue;
      logic last;
      logic clear;
   } unit_cmd_type;

   typedef struct packed {
      logic [REGION_BITS-1:0] region;
      logic                   no_match;
      logic [DIST_BITS-1:0]   distortion;
   } result_type;

   // Tokhura weights; positions past the twelfth keep the last weight.
   function automatic logic [WEIGHT_BITS-1:0] tok_weight(input logic [3:0] pos);
      logic [WEIGHT_BITS-1:0] w;
      unique case (pos)
         4'd0:    w = 6'd1;
         4'd1:    w = 6'd3;
         4'd2:    w = 6'd7;
         4'd3:    w = 6'd13;
         4'd4:    w = 6'd19;
         4'd5:    w = 6'd22;
         4'd6:    w = 6'd25;
         4'd7:    w = 6'd33;
         4'd8:    w = 6'd42;
         4'd9:    w = 6'd50;
         4'd10:   w = 6'd56;
         4'd11:   w = 6'd61;
         4'd12:   w = 6'd61;
         4'd13:   w = 6'd61;
         4'd14:   w = 6'd61;
         4'd15:   w = 6'd61;
      endcase
      return w;
   endfunction

endpackage

// ----- hdl/tnc_codeword_store.sv -----
// Codeword memory: one write port for loads, one registered read port.
// Depends on nothing but its parameters.
module tnc_codeword_store #(
   parameter int DEPTH       = 96,
   parameter int ADDR_BITS   = 7,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_BITS-1:0]   wr_addr,
   input  logic [SAMPLE_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0]   rd_addr,
   output logic [SAMPLE_BITS-1:0] rd_data
);

   logic [SAMPLE_BITS-1:0] store_ff [DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/tnc_tokhura_unit.sv -----
// Shared weighted-square accumulate unit with the per-codeword accumulators
// and the running minimum search. Depends on tnc_pkg.
module tnc_tokhura_unit
   import tnc_pkg::*;
#(
   parameter int CODEBOOK_ENTRIES = 8,
   parameter int IDX_BITS         = 3,
   parameter int SAMPLE_BITS      = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  unit_cmd_type                  cmd,
   input  logic [IDX_BITS-1:0]           cmd_idx,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic [SAMPLE_BITS-1:0]        codeword,
   input  logic [WEIGHT_BITS-1:0]        weight,
   input  logic [3:0]                    codebook_size,
   input  logic [DIST_BITS-1:0]          limit,
   output logic                          busy,
   output result_type                    result
);

   localparam int SQ_BITS   = 2 * SAMPLE_BITS;
   localparam int TERM_BITS = SQ_BITS + WEIGHT_BITS;
   localparam int EXT_BITS  = (TERM_BITS > DIST_BITS) ? TERM_BITS : DIST_BITS + 1;

   logic                   v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic                   last1_ff, last2_ff, last3_ff, last4_ff, last5_ff;
   logic [IDX_BITS-1:0]    idx1_ff, idx2_ff, idx3_ff, idx4_ff, idx5_ff;
   logic [SAMPLE_BITS-1:0] absd2_ff;
   logic [SQ_BITS-1:0]     sq3_ff;
   logic [DIST_BITS-1:0]   term4_ff;
   logic [DIST_BITS-1:0]   sum5_ff;
   logic [DIST_BITS-1:0]   acc_ff [CODEBOOK_ENTRIES];
   logic [DIST_BITS-1:0]   best_ff;
   logic [IDX_BITS-1:0]    region_ff;
   logic                   found_ff;

   logic signed [SAMPLE_BITS:0] diff, diff_neg;
   logic [SAMPLE_BITS-1:0]      absd;
   logic [TERM_BITS-1:0]        term;
   logic [EXT_BITS-1:0]         term_ext;
   logic [DIST_BITS-1:0]        term_sat;
   logic [DIST_BITS:0]          sum_wide;
   logic [DIST_BITS-1:0]        sum_sat;
   logic [DIST_BITS-1:0]        base_best;
   logic [IDX_BITS-1:0]         base_region;
   logic                        base_found;
   logic                        take;

   always_comb begin
      diff     = $signed({sample[SAMPLE_BITS-1], sample})
               - $signed({codeword[SAMPLE_BITS-1], codeword});
      diff_neg = -diff;
      absd     = diff[SAMPLE_BITS] ? diff_neg[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];

      term     = sq3_ff * weight;
      term_ext = EXT_BITS'(term);
      term_sat = (term_ext > EXT_BITS'(DIST_MAX)) ? DIST_MAX : term_ext[DIST_BITS-1:0];

      sum_wide = {1'b0, acc_ff[idx4_ff]} + {1'b0, term4_ff};
      sum_sat  = sum_wide[DIST_BITS] ? DIST_MAX : sum_wide[DIST_BITS-1:0];

      // The first codeword of a closing vector compares against the limit.
      if (idx5_ff == '0) begin
         base_best   = limit;
         base_region = '0;
         base_found  = 1'b0;
      end else begin
         base_best   = best_ff;
         base_region = region_ff;
         base_found  = found_ff;
      end
      take = (32'(idx5_ff) < 32'(codebook_size)) && (sum5_ff < base_best);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff  <= cmd_idx;
      last1_ff <= cmd.last;
      idx2_ff  <= idx1_ff;
      last2_ff <= last1_ff;
      idx3_ff  <= idx2_ff;
      last3_ff <= last2_ff;
      idx4_ff  <= idx3_ff;
      last4_ff <= last3_ff;
      idx5_ff  <= idx4_ff;
      last5_ff <= last4_ff;
      absd2_ff <= absd;
      sq3_ff   <= absd2_ff * absd2_ff;
      term4_ff <= term_sat;
      sum5_ff  <= sum_sat;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < CODEBOOK_ENTRIES; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (v4_ff) begin
         acc_ff[idx4_ff] <= sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (v5_ff && last5_ff) begin
         best_ff   <= take ? sum5_ff : base_best;
         region_ff <= take ? idx5_ff : base_region;
         found_ff  <= take | base_found;
      end
   end

   assign busy              = v1_ff | v2_ff | v3_ff | v4_ff | v5_ff;
   assign result.region     = REGION_BITS'(region_ff);
   assign result.no_match   = ~found_ff;
   assign result.distortion = best_ff;

endmodule

// ----- hdl/tnc_sequencer.sv -----
// Sequencer: walks the codewords through the shared unit for one element,
// waits for the pipeline to drain and hands off a finished vector.
// Depends on tnc_pkg.
module tnc_sequencer
   import tnc_pkg::*;
#(
   parameter int CODEBOOK_ENTRIES = 8,
   parameter int VECTOR_LENGTH    = 12,
   parameter int IDX_BITS         = 3,
   parameter int ADDR_BITS        = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 start_last,
   input  logic [3:0]           start_elem,
   input  logic                 unit_busy,
   input  logic                 out_free,
   output logic                 busy,
   output unit_cmd_type         cmd,
   output logic [IDX_BITS-1:0]  cmd_idx,
   output logic [ADDR_BITS-1:0] rd_addr,
   output logic                 load_result
);

   seq_state_type        state_ff, state_in;
   logic [IDX_BITS-1:0]  cnt_ff, cnt_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic                 last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
      end
      addr_ff <= addr_in;
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      addr_in     = addr_ff;
      last_in     = last_ff;
      cmd         = '0;
      load_result = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cnt_in   = '0;
               addr_in  = ADDR_BITS'(start_elem);
               last_in  = start_last;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            cmd.last  = last_ff;
            addr_in   = addr_ff + ADDR_BITS'(VECTOR_LENGTH);
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == IDX_BITS'(CODEBOOK_ENTRIES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!unit_busy) begin
               state_in = last_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               load_result = 1'b1;
               cmd.clear   = 1'b1;
               state_in    = ST_IDLE;
            end
         end
      endcase
   end

   assign busy    = (state_ff != ST_IDLE);
   assign cmd_idx = cnt_ff;
   assign rd_addr = addr_ff;

endmodule

// ----- hdl/tokhura_nearest_codeword.sv -----
// Top level of the Tokhura nearest-codeword vector-quantizer encoder.
// Depends on tnc_pkg, tnc_codeword_store, tnc_tokhura_unit and tnc_sequencer.

// A codeword-load beat (req_type 0) writes one element of the codebook and
// the block can take the next beat right away. A training beat (req_type 1)
// makes the sequencer run every codeword through one shared difference,
// square, weight and saturating-accumulate pipeline, one codeword a cycle,
// and then wait for that five-stage pipeline to drain before it takes the
// next beat; after the beat that closes a vector, the result first goes into
// the output register. That register lets the next vector be worked on while
// the result waits; only a second finished result holds the block until the
// first one has been taken. Ties go to the lower codeword index, only the
// first codebook_size codewords compete, and no_match reports that none of
// them fell below no_match_limit, in which case the region is zero and the
// distortion is the limit itself. Beats with an element index outside the
// vector, and loads to a codeword beyond the codebook, are accepted and
// dropped. The codebook has no reset: only loaded entries may be used. The
// CSR port is always ready and should be written only while the block is
// idle.
module tokhura_nearest_codeword
   import tnc_pkg::*;
#(
   parameter int SAMPLE_BITS      = 16
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [2:0]                    req_codeword_index,
   input  logic [3:0]                    req_element_index,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_value,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [REGION_BITS-1:0]        rsp_nearest_region,
   output logic                          rsp_no_match,
   output logic [DIST_BITS-1:0]          rsp_distortion,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [0:0]                    csr_index,
   input  logic [DIST_BITS-1:0]          csr_data
);

   localparam int DEPTH     = CODEBOOK_ENTRIES * VECTOR_LENGTH;
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_BITS  = (CODEBOOK_ENTRIES > 1) ? $clog2(CODEBOOK_ENTRIES) : 1;

   logic [3:0]                    size_ff;
   logic [DIST_BITS-1:0]          limit_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic [WEIGHT_BITS-1:0]        weight_ff;
   logic                          rsp_valid_ff;
   result_type                    rsp_ff;

   logic                 accept, elem_ok, cw_ok, is_train, is_last;
   logic                 store_wr, start;
   logic [ADDR_BITS-1:0] wr_addr, rd_addr;
   logic [SAMPLE_BITS-1:0] rd_data;
   logic                 seq_busy, unit_busy, out_free, load_result;
   unit_cmd_type         cmd;
   logic [IDX_BITS-1:0]  cmd_idx;
   result_type           result;

   // The CSR port never pushes back.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= SIZE_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CODEBOOK_SIZE:  size_ff  <= csr_data[3:0];
            CSR_NO_MATCH_LIMIT: limit_ff <= csr_data;
         endcase
      end
   end

   // Decode of the incoming beat.
   assign accept   = req_valid && !req_stall;
   assign elem_ok  = 32'(req_element_index) < VECTOR_LENGTH;
   assign cw_ok    = 32'(req_codeword_index) < CODEBOOK_ENTRIES;
   assign is_train = (req_type == REQ_TRAIN);
   assign is_last  = 32'(req_element_index) == VECTOR_LENGTH - 1;
   assign store_wr = accept && !is_train && elem_ok && cw_ok;
   assign start    = accept && is_train && elem_ok;
   assign wr_addr  = ADDR_BITS'(32'(req_codeword_index) * VECTOR_LENGTH
                               + 32'(req_element_index));

   // The sample and its weight stay put for the whole pass over the codebook.
   always_ff @(posedge clock) begin
      if (start) begin
         sample_ff <= req_sample_value;
         weight_ff <= tok_weight(req_element_index);
      end
   end

   tnc_codeword_store #(
      .DEPTH       (DEPTH),
      .ADDR_BITS   (ADDR_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (wr_addr),
      .wr_data (req_sample_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tnc_sequencer #(
      .CODEBOOK_ENTRIES (CODEBOOK_ENTRIES),
      .VECTOR_LENGTH    (VECTOR_LENGTH),
      .IDX_BITS         (IDX_BITS),
      .ADDR_BITS        (ADDR_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .start_last  (is_last),
      .start_elem  (req_element_index),
      .unit_busy   (unit_busy),
      .out_free    (out_free),
      .busy        (seq_busy),
      .cmd         (cmd),
      .cmd_idx     (cmd_idx),
      .rd_addr     (rd_addr),
      .load_result (load_result)
   );

   tnc_tokhura_unit #(
      .CODEBOOK_ENTRIES (CODEBOOK_ENTRIES),
      .IDX_BITS         (IDX_BITS),
      .SAMPLE_BITS      (SAMPLE_BITS)
   ) u_unit (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cmd_idx       (cmd_idx),
      .sample        (sample_ff),
      .codeword      (rd_data),
      .weight        (weight_ff),
      .codebook_size (size_ff),
      .limit         (limit_ff),
      .busy          (unit_busy),
      .result        (result)
   );

   assign req_stall = seq_busy;

   // Output register: free when empty or when its beat leaves this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_result) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_nearest_region = rsp_ff.region;
   assign rsp_no_match       = rsp_ff.no_match;
   assign rsp_distortion     = rsp_ff.distortion;

endmodule
